[src/bresenham_line_stepper_top_assert.svh]
// Assertion macros for the line stepper top level.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH
`define BRESENHAM_LINE_STEPPER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BLS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line stepper check failed");

`define BLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line stepper check failed");

`else

`define BLS_ASSERT_SAME(lbl, ante, cons)

`define BLS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[src/bls_pkg.sv]
// Shared types and constants for the Bresenham line stepper.
// No dependencies; used by bls_step_logic and bresenham_line_stepper_top.
package bls_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_BITS   = 15;
  localparam int TD_BITS    = COORD_BITS + 2;
  localparam int ERR_BITS   = COORD_BITS + 4;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 15'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 15'd480;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_BITS-1:0] cfg_word_t;
  typedef logic [0:0] cfg_idx_t;

  typedef struct packed {
    logic   func;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   keep;
    logic   last;
  } out_item_t;

  typedef struct packed {
    coord_t                     cur_x;
    coord_t                     cur_y;
    coord_t                     tgt_x;
    coord_t                     tgt_y;
    logic signed [ERR_BITS-1:0] err;
    logic [TD_BITS-1:0]         tdx;
    logic [TD_BITS-1:0]         tdy;
    logic signed [1:0]          sx;
    logic signed [1:0]          sy;
    logic                       x_major;
    logic                       active;
  } line_state_t;

  typedef struct packed {
    cfg_word_t width;
    cfg_word_t height;
  } screen_cfg_t;

endpackage

[src/bls_step_logic.sv]
// Combinational start and step logic of the line stepper: next line state and result.
// Depends on bls_pkg.
module bls_step_logic (
  input  bls_pkg::in_item_t    item,
  input  bls_pkg::line_state_t state,
  input  bls_pkg::screen_cfg_t scr,
  output bls_pkg::line_state_t state_nxt,
  output bls_pkg::out_item_t   result
);

  localparam int CB  = bls_pkg::COORD_BITS;
  localparam int EB  = bls_pkg::ERR_BITS;
  localparam int CMP = bls_pkg::COORD_BITS + bls_pkg::CFG_BITS;

  logic signed [CB:0]      dx;
  logic signed [CB:0]      dy;
  logic [CB:0]             adx;
  logic [CB:0]             ady;
  logic [bls_pkg::TD_BITS-1:0] tdx_s;
  logic [bls_pkg::TD_BITS-1:0] tdy_s;
  logic                    xm_s;
  logic                    take;
  logic                    maj_pos;
  bls_pkg::coord_t         sx_ext;
  bls_pkg::coord_t         sy_ext;
  bls_pkg::coord_t         nx;
  bls_pkg::coord_t         ny;
  logic                    x_in;
  logic                    y_in;

  always_comb begin
    dx    = {item.end_x[CB-1], item.end_x} - {item.start_x[CB-1], item.start_x};
    dy    = {item.end_y[CB-1], item.end_y} - {item.start_y[CB-1], item.start_y};
    adx   = dx[CB] ? ((CB+1)'(0) - $unsigned(dx)) : $unsigned(dx);
    ady   = dy[CB] ? ((CB+1)'(0) - $unsigned(dy)) : $unsigned(dy);
    tdx_s = {adx, 1'b0};
    tdy_s = {ady, 1'b0};
    xm_s  = tdx_s >= tdy_s;

    sx_ext = {{(CB-2){state.sx[1]}}, state.sx};
    sy_ext = {{(CB-2){state.sy[1]}}, state.sy};
    maj_pos = state.x_major ? (!state.sx[1] && state.sx[0]) : (!state.sy[1] && state.sy[0]);
    take = (!state.err[EB-1] && (state.err != '0)) || ((state.err == '0) && maj_pos);

    state_nxt = state;
    result    = '0;
    nx        = state.cur_x;
    ny        = state.cur_y;
    x_in      = 1'b0;
    y_in      = 1'b0;

    if (item.func == bls_pkg::FUNC_START) begin
      state_nxt.cur_x   = item.start_x;
      state_nxt.cur_y   = item.start_y;
      state_nxt.tgt_x   = item.end_x;
      state_nxt.tgt_y   = item.end_y;
      state_nxt.tdx     = tdx_s;
      state_nxt.tdy     = tdy_s;
      state_nxt.sx      = dx[CB] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
      state_nxt.sy      = dy[CB] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
      state_nxt.x_major = xm_s;
      if (xm_s) begin
        state_nxt.err    = $signed(EB'(tdy_s) - EB'(adx));
        state_nxt.active = item.start_x != item.end_x;
      end else begin
        state_nxt.err    = $signed(EB'(tdx_s) - EB'(ady));
        state_nxt.active = item.start_y != item.end_y;
      end
      result.point_x = item.start_x;
      result.point_y = item.start_y;
      result.keep    = 1'b1;
      result.last    = !state_nxt.active;
    end else if (!state.active) begin
      result.point_x = state.cur_x;
      result.point_y = state.cur_y;
      result.keep    = 1'b0;
      result.last    = 1'b1;
    end else begin
      if (state.x_major) begin
        nx = state.cur_x + sx_ext;
        ny = take ? (state.cur_y + sy_ext) : state.cur_y;
        state_nxt.err = $signed($unsigned(state.err) - (take ? EB'(state.tdx) : EB'(0))
                                + EB'(state.tdy));
        state_nxt.active = nx != state.tgt_x;
      end else begin
        ny = state.cur_y + sy_ext;
        nx = take ? (state.cur_x + sx_ext) : state.cur_x;
        state_nxt.err = $signed($unsigned(state.err) - (take ? EB'(state.tdy) : EB'(0))
                                + EB'(state.tdx));
        state_nxt.active = ny != state.tgt_y;
      end
      state_nxt.cur_x = nx;
      state_nxt.cur_y = ny;
      x_in = !nx[CB-1] && (CMP'($unsigned(nx)) < CMP'(scr.width));
      y_in = !ny[CB-1] && (CMP'($unsigned(ny)) < CMP'(scr.height));
      result.point_x = nx;
      result.point_y = ny;
      result.keep    = x_in && y_in;
      result.last    = !state_nxt.active;
    end
  end

endmodule

[src/bresenham_line_stepper_top.sv]
// Top level of the Bresenham line stepper: handshakes, line state and screen registers.
// Depends on bls_pkg, bls_step_logic and bresenham_line_stepper_top_assert.svh.
//
//   channel | direction | signals                         | moves
//   in      | input     | in_valid, in_stall, in_item     | start or step item
//   out     | output    | out_valid, out_stall, out_item  | one point item per input item
//   cfg     | input     | cfg_we, cfg_index, cfg_wdata    | screen width and height writes
//
// One item is taken every cycle unless in_stall is high; each item passes through the input
// register and then the result register, with the line update in between.
// Synchronous active-low reset clears the line state and sets a 640 by 480 screen.
// A stalled result holds its register; the input register still takes one more item,
// and in_stall rises only when both registers are full.
`include "bresenham_line_stepper_top_assert.svh"

module bresenham_line_stepper_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bls_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output bls_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  bls_pkg::cfg_idx_t   cfg_index,
  input  bls_pkg::cfg_word_t  cfg_wdata
);

  logic                 in_valid_r;
  logic                 in_valid_nxt;
  bls_pkg::in_item_t    in_item_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  bls_pkg::out_item_t   out_item_r;
  bls_pkg::line_state_t state_r;
  bls_pkg::line_state_t state_nxt;
  bls_pkg::out_item_t   result;
  bls_pkg::screen_cfg_t scr_r;
  bls_pkg::screen_cfg_t scr_nxt;
  logic                 out_free;
  logic                 s1_adv;
  logic                 in_acc;

  bls_step_logic u_step (
    .item      (in_item_r),
    .state     (state_r),
    .scr       (scr_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    s1_adv        = in_valid_r && out_free;
    in_stall      = in_valid_r && !out_free;
    in_acc        = in_valid && !in_stall;
    in_valid_nxt  = in_acc || (in_valid_r && !s1_adv);
    out_valid_nxt = out_free ? s1_adv : out_valid_r;
    scr_nxt       = scr_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bls_pkg::CFG_IDX_WIDTH:  scr_nxt.width  = cfg_wdata;
        bls_pkg::CFG_IDX_HEIGHT: scr_nxt.height = cfg_wdata;
        default:                 scr_nxt        = scr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
      scr_r.width  <= bls_pkg::WIDTH_RESET;
      scr_r.height <= bls_pkg::HEIGHT_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      scr_r       <= scr_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `BLS_ASSERT_SAME(a_active_x, state_r.active && state_r.x_major, state_r.cur_x != state_r.tgt_x)
  `BLS_ASSERT_SAME(a_active_y, state_r.active && !state_r.x_major, state_r.cur_y != state_r.tgt_y)
  `BLS_ASSERT_SAME(a_major_dom, state_r.active && state_r.x_major, state_r.tdx >= state_r.tdy)
  `BLS_ASSERT_NEXT(a_start_kept, s1_adv && (in_item_r.func == bls_pkg::FUNC_START), out_valid && out_item.keep)

endmodule
